FILE: design/acpu_pkg.sv
// Shared types, opcodes and constants of the accumulator CPU core.
package acpu_pkg;

    // Memory address width; pc and all addresses wrap at this width.
    localparam int ADDR_BITS = 8;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] ADDR_ONE = 1;

    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Item kinds on the input tuser bit.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [7:0] {
        OP_LDA  = 8'd0,
        OP_STA  = 8'd1,
        OP_ADD  = 8'd2,
        OP_SUB  = 8'd3,
        OP_AND  = 8'd4,
        OP_OR   = 8'd5,
        OP_XOR  = 8'd6,
        OP_NOT  = 8'd7,
        OP_LLA  = 8'd8,
        OP_NOP0 = 8'd9,
        OP_JMP  = 8'd10,
        OP_JZ   = 8'd11,
        OP_IN   = 8'd12,
        OP_OUT  = 8'd13,
        OP_NOP1 = 8'd14,
        OP_STP  = 8'd15,
        OP_LDB  = 8'd16,
        OP_STB  = 8'd17,
        OP_LDC  = 8'd18,
        OP_STC  = 8'd19,
        OP_MUL  = 8'd20,
        OP_DIV  = 8'd21,
        OP_LLB  = 8'd22,
        OP_LLC  = 8'd23,
        OP_NOP2 = 8'd24
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_LOAD_RD,
        ST_DIV,
        ST_EXEC,
        ST_REPORT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // input item accepted this cycle
        logic load_write;  // accepted item is a memory write
        logic fetch_rd;    // read instruction word at pc
        logic data_rd;     // read data word at the argument address
        logic decode;      // latch instruction, prime the divider
        logic div_step;    // one divider iteration
        logic execute;     // commit the instruction and load the result
        logic report;      // load the result without changing state
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [7:0] fetch_op;  // opcode of the fetched word
        logic       stopped;
        logic       b_zero;
        logic       out_free;  // output register can take a result
    } dp_status_t;

endpackage

FILE: design/acpu_ctrl.sv
// Controller state machine of the accumulator CPU core.
module acpu_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   kind,
    input  acpu_pkg::dp_status_t   status,
    output acpu_pkg::ctrl_cmd_t    cmd
);

    acpu_pkg::ctrl_state_t state_reg, state_next;
    logic [acpu_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic is_load_op;

    assign is_load_op = (status.fetch_op == acpu_pkg::OP_LDA) ||
                        (status.fetch_op == acpu_pkg::OP_LDB) ||
                        (status.fetch_op == acpu_pkg::OP_LDC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acpu_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg) inside
            acpu_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (kind == acpu_pkg::KIND_LOAD || status.stopped)
                        state_next = acpu_pkg::ST_REPORT;
                    else
                        state_next = acpu_pkg::ST_FETCH;
                end
            end
            acpu_pkg::ST_FETCH:
                state_next = acpu_pkg::ST_DECODE;
            acpu_pkg::ST_DECODE:
            begin
                cnt_next = '0;
                if (is_load_op)
                    state_next = acpu_pkg::ST_LOAD_RD;
                else if (status.fetch_op == acpu_pkg::OP_DIV && !status.b_zero)
                    state_next = acpu_pkg::ST_DIV;
                else
                    state_next = acpu_pkg::ST_EXEC;
            end
            acpu_pkg::ST_LOAD_RD:
                state_next = acpu_pkg::ST_EXEC;
            acpu_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == acpu_pkg::DIV_LAST)
                    state_next = acpu_pkg::ST_EXEC;
            end
            acpu_pkg::ST_EXEC,
            acpu_pkg::ST_REPORT:
            begin
                if (status.out_free)
                    state_next = acpu_pkg::ST_IDLE;
            end
            default:
                state_next = acpu_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            acpu_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.take       = s_tvalid;
                cmd.load_write = s_tvalid && (kind == acpu_pkg::KIND_LOAD);
            end
            acpu_pkg::ST_FETCH:   cmd.fetch_rd = 1'b1;
            acpu_pkg::ST_DECODE:  cmd.decode   = 1'b1;
            acpu_pkg::ST_LOAD_RD: cmd.data_rd  = 1'b1;
            acpu_pkg::ST_DIV:     cmd.div_step = 1'b1;
            acpu_pkg::ST_EXEC:    cmd.execute  = status.out_free;
            acpu_pkg::ST_REPORT:  cmd.report   = status.out_free;
            default:              cmd          = '0;
        endcase
    end

    // The divider runs exactly its fixed number of iterations.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acpu_pkg::ST_DIV && cnt_reg == acpu_pkg::DIV_LAST)
        |=> state_reg == acpu_pkg::ST_EXEC)
        else $error("divider did not finish after its last iteration");

    // A step item on a running core always starts with a fetch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && kind == acpu_pkg::KIND_STEP && !status.stopped)
        |=> state_reg == acpu_pkg::ST_FETCH)
        else $error("step item did not start a fetch");

endmodule

FILE: design/acpu_dpath.sv
// Datapath of the accumulator CPU core: registers, memory, ALU, divider, result register.
module acpu_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acpu_pkg::ctrl_cmd_t                 cmd,
    output acpu_pkg::dp_status_t                status,
    input  logic [acpu_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acpu_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    localparam int AW = acpu_pkg::ADDR_BITS;

    logic [acpu_pkg::WORD_W-1:0] mem [acpu_pkg::MEM_WORDS];
    logic [acpu_pkg::WORD_W-1:0] mem_rdata_reg;
    logic [acpu_pkg::WORD_W-1:0] ir_reg;
    logic [7:0] in_char_reg;

    logic [7:0] a_reg, b_reg, c_reg;
    logic [7:0] a_next, b_next, c_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic zf_reg, zf_next, of_reg, of_next, stopped_reg, stopped_next;

    // Divider state.
    logic [7:0] rem_reg, qd_reg, dvs_reg;
    logic a_neg_reg, b_neg_reg;
    logic [8:0] div_shift;
    logic div_ge;

    // Result register.
    logic m_valid_reg;
    logic strobe_reg, halted_reg, zf_out_reg, of_out_reg;
    logic [7:0] char_reg, acc_reg, pc_out_reg;

    logic [7:0] op, arg;
    logic [AW-1:0] arg_addr;
    logic signed [15:0] a16, b16, sum16, diff16, prod16, quo16;
    logic [7:0] rem8;
    logic logic_en, arith_en, strobe, is_store;
    logic [7:0] lv, st_val;
    logic [15:0] ar;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [acpu_pkg::WORD_W-1:0] mem_wdata;
    logic load_result;

    assign op       = ir_reg[15:8];
    assign arg      = ir_reg[7:0];
    assign arg_addr = ir_reg[AW-1:0];

    assign a16    = signed'({{8{a_reg[7]}}, a_reg});
    assign b16    = signed'({{8{b_reg[7]}}, b_reg});
    assign sum16  = a16 + b16;
    assign diff16 = a16 - b16;
    assign prod16 = a16 * b16;
    assign quo16  = (a_neg_reg ^ b_neg_reg) ? -signed'({8'd0, qd_reg})
                                            : signed'({8'd0, qd_reg});
    assign rem8   = a_neg_reg ? 8'(-rem_reg) : rem_reg;

    // Memory: one write port, one registered read port.
    assign mem_raddr = cmd.fetch_rd ? pc_reg : arg_addr;
    assign mem_we    = cmd.load_write || (cmd.execute && is_store);
    assign mem_waddr = cmd.load_write ? s_tdata[AW-1:0] : arg_addr;
    assign mem_wdata = cmd.load_write ? s_tdata[23:8] : {{8{st_val[7]}}, st_val};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.fetch_rd || cmd.data_rd)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // Instruction execution.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        pc_next      = pc_reg;
        zf_next      = zf_reg;
        of_next      = of_reg;
        stopped_next = stopped_reg;
        logic_en     = 1'b0;
        arith_en     = 1'b0;
        strobe       = 1'b0;
        is_store     = 1'b0;
        lv           = '0;
        ar           = '0;
        st_val       = a_reg;
        if (cmd.execute)
        begin
            pc_next = pc_reg + acpu_pkg::ADDR_ONE;
            unique case (op) inside
                acpu_pkg::OP_LDA:
                begin
                    lv = mem_rdata_reg[7:0]; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_LDB:
                begin
                    lv = mem_rdata_reg[7:0]; b_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_LDC:
                begin
                    lv = mem_rdata_reg[7:0]; c_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_STA:
                begin
                    is_store = 1'b1; st_val = a_reg;
                end
                acpu_pkg::OP_STB:
                begin
                    is_store = 1'b1; st_val = b_reg;
                end
                acpu_pkg::OP_STC:
                begin
                    is_store = 1'b1; st_val = c_reg;
                end
                acpu_pkg::OP_ADD:
                begin
                    ar = sum16; a_next = sum16[7:0]; arith_en = 1'b1;
                end
                acpu_pkg::OP_SUB:
                begin
                    ar = diff16; a_next = diff16[7:0]; arith_en = 1'b1;
                end
                acpu_pkg::OP_MUL:
                begin
                    ar = prod16; a_next = prod16[7:0]; arith_en = 1'b1;
                end
                acpu_pkg::OP_AND:
                begin
                    lv = a_reg & b_reg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_OR:
                begin
                    lv = a_reg | b_reg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_XOR:
                begin
                    lv = a_reg ^ b_reg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_NOT:
                begin
                    lv = ~a_reg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_LLA:
                begin
                    lv = arg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_LLB:
                begin
                    lv = arg; b_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_LLC:
                begin
                    lv = arg; c_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_IN:
                begin
                    lv = in_char_reg; a_next = lv; logic_en = 1'b1;
                end
                acpu_pkg::OP_JMP:
                    pc_next = arg_addr + acpu_pkg::ADDR_ONE;
                acpu_pkg::OP_JZ:
                begin
                    if (zf_reg)
                        pc_next = arg_addr + acpu_pkg::ADDR_ONE;
                end
                acpu_pkg::OP_OUT:
                    strobe = 1'b1;
                acpu_pkg::OP_STP:
                    stopped_next = 1'b1;
                acpu_pkg::OP_DIV:
                begin
                    // Division by zero: quotient 0 with both flags set, B kept.
                    if (b_reg == 8'd0)
                    begin
                        a_next  = 8'd0;
                        zf_next = 1'b1;
                        of_next = 1'b1;
                    end
                    else
                    begin
                        b_next   = rem8;
                        ar       = quo16;
                        a_next   = quo16[7:0];
                        arith_en = 1'b1;
                    end
                end
                acpu_pkg::OP_NOP0,
                acpu_pkg::OP_NOP1,
                acpu_pkg::OP_NOP2:
                    pc_next = pc_reg + acpu_pkg::ADDR_ONE;
                default:
                    pc_next = pc_reg + acpu_pkg::ADDR_ONE;
            endcase
            if (logic_en)
            begin
                zf_next = (lv == 8'd0);
                of_next = 1'b0;
            end
            if (arith_en)
            begin
                // Outside -128..127 exactly when the upper nine bits disagree.
                zf_next = (ar[7:0] == 8'd0);
                of_next = !((ar[15:7] == 9'h000) || (ar[15:7] == 9'h1FF));
            end
        end
    end

    // Architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg       <= '0;
            b_reg       <= '0;
            c_reg       <= '0;
            pc_reg      <= '0;
            zf_reg      <= 1'b0;
            of_reg      <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            pc_reg      <= pc_next;
            zf_reg      <= zf_next;
            of_reg      <= of_next;
            stopped_reg <= stopped_next;
        end
    end

    // Item payload, instruction register and restoring divider on magnitudes.
    assign div_shift = {rem_reg, qd_reg[7]};
    assign div_ge    = (div_shift >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            in_char_reg <= s_tdata[31:24];
        if (cmd.decode)
        begin
            ir_reg    <= mem_rdata_reg;
            a_neg_reg <= a_reg[7];
            b_neg_reg <= b_reg[7];
            qd_reg    <= a_reg[7] ? 8'(-a_reg) : a_reg;
            dvs_reg   <= b_reg[7] ? 8'(-b_reg) : b_reg;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 8'(div_shift - {1'b0, dvs_reg}) : div_shift[7:0];
            qd_reg  <= {qd_reg[6:0], div_ge};
        end
    end

    // Result register.
    assign load_result = cmd.execute || cmd.report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_result)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            strobe_reg <= strobe;
            char_reg   <= strobe ? a_next : 8'd0;
            halted_reg <= stopped_next;
            acc_reg    <= a_next;
            pc_out_reg <= 8'(pc_next);
            zf_out_reg <= zf_next;
            of_out_reg <= of_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = strobe_reg;
    assign m_tdata  = {5'd0, of_out_reg, zf_out_reg, pc_out_reg, acc_reg,
                       halted_reg, char_reg};

    assign status.fetch_op = mem_rdata_reg[15:8];
    assign status.stopped  = stopped_reg;
    assign status.b_zero   = (b_reg == 8'd0);
    assign status.out_free = !m_valid_reg || m_tready;

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while held");

    // Once halted the core stays halted.
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped bit cleared");

endmodule

FILE: design/accumulator_cpu_core.sv
// Top level of the accumulator CPU core: controller and datapath.
//
//  channel  | direction | tdata (low bit first)                          | tuser
//  ---------+-----------+------------------------------------------------+-----------
//  s_axis   | in        | load_address, load_word, in_char               | kind
//  m_axis   | out       | out_char, halted, acc_value, prog_counter,     | out_strobe
//           |           | zero_flag, overflow_flag, five zero bits       |
//
// A write item is accepted and then reported. A step item passes through fetch, decode
// and commit; lda, ldb and ldc add a second memory read before the commit, and a division
// by a nonzero B adds eight iterations of the shift-subtract divider; a division by zero
// skips the divider. A step item on a halted core is reported without a fetch.
// Reset (rst_n low, asynchronous) clears A, B, C, pc, the flags and the stopped bit; the
// memory is not cleared. One item is in work at a time: s_tready is high only while the
// controller waits for an item, and a finished result waits in the output register while
// m_tready is low, holding the next commit back until it has been taken.
module accumulator_cpu_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // load_address [7:0], load_word [23:8], in_char [31:24]
    input  logic [acpu_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_char [7:0], halted [8], acc_value [16:9], prog_counter [24:17],
    // zero_flag [25], overflow_flag [26], zero [31:27]
    output logic [acpu_pkg::M_TDATA_W-1:0]    m_tdata,
    // out_strobe [0]
    output logic                              m_tuser
);

    acpu_pkg::ctrl_cmd_t  cmd;
    acpu_pkg::dp_status_t status;

    // The controller sequences fetch, decode, operand read, division and commit.
    acpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, memory, ALU, divider and the result register.
    acpu_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the accumulator CPU core.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcode that the core must treat as a no-op (anything above the last defined one).
    localparam logic [7:0] BAD_OPCODE = 8'hFF;

    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off to back the core up
    localparam int DRAIN_CYCLES = 24;       // a division plus a report, with margin
    localparam int TIMEOUT_NS   = 5_000_000;

    // One expected result item, field for field as it leaves the core.
    typedef struct packed {
        logic       strobe;
        logic [7:0] out_char;
        logic       halted;
        logic [7:0] acc;
        logic [7:0] pc;
        logic       zero;
        logic       ovf;
    } cpu_report_t;

    // One row of the directed table. For a step row on a running core the
    // instruction word is written at the current pc first, then executed. Rows
    // with typed set carry the accumulator and flags that can be read off by hand.
    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic [7:0]  addr;
        logic [7:0]  in_char;
        logic        typed;
        logic [7:0]  acc;
        logic        zero;
        logic        ovf;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // load_address [7:0], load_word [23:8], in_char [31:24]
    logic [31:0] s_tdata  = '0;
    // kind [0]
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // out_char [7:0], halted [8], acc_value [16:9], prog_counter [24:17],
    // zero_flag [25], overflow_flag [26], zero [31:27]
    logic [31:0] m_tdata;
    // out_strobe [0]
    logic        m_tuser;

    // Predicted architectural state of the core.
    logic [7:0]                    cpu_a, cpu_b, cpu_c;
    logic [acpu_pkg::ADDR_BITS-1:0] cpu_pc;
    logic                          cpu_zero, cpu_ovf, cpu_halted;
    logic [15:0]                   cpu_mem [acpu_pkg::MEM_WORDS];
    bit                            cpu_mem_valid [acpu_pkg::MEM_WORDS];

    cpu_report_t pending_reports [$];
    stim_row_t   stim_rows [$];
    int          halt_first;
    int          items_offered = 0;
    int          fail_count = 0;
    int          tx_idle_pct = 24;
    int          rx_idle_pct = 55;
    bit          hold_requested = 1'b0;

    accumulator_cpu_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Loads, immediates, in and the logic operations: zero from the byte,
    // overflow cleared.
    function automatic logic [7:0] logic_result(logic [7:0] v);
        cpu_ovf  = 1'b0;
        cpu_zero = (v == 8'h00);
        return v;
    endfunction

    // add, sub, mul and div: the exact result decides overflow; the low byte
    // decides zero and is what lands in the register.
    function automatic logic [7:0] arith_result(int r);
        logic [7:0] lo;
        lo       = 8'(r);
        cpu_ovf  = (r < -128) || (r > 127);
        cpu_zero = (lo == 8'h00);
        return lo;
    endfunction

    // Stores write the register sign-extended to a full word.
    function automatic void store_word(logic [acpu_pkg::ADDR_BITS-1:0] ea, logic [7:0] v);
        cpu_mem[ea]       = {{8{v[7]}}, v};
        cpu_mem_valid[ea] = 1'b1;
    endfunction

    function automatic cpu_report_t predict_report(logic kind, logic [7:0] addr,
                                                   logic [15:0] word, logic [7:0] in_char);
        cpu_report_t                    rpt;
        logic [7:0]                     op;
        logic [7:0]                     arg;
        logic [acpu_pkg::ADDR_BITS-1:0] ea;
        int                             a;
        int                             b;
        int                             rem;
        rpt = '0;
        if (kind == acpu_pkg::KIND_LOAD)
        begin
            // A memory write goes through even on a halted core.
            cpu_mem[addr[acpu_pkg::ADDR_BITS-1:0]]       = word;
            cpu_mem_valid[addr[acpu_pkg::ADDR_BITS-1:0]] = 1'b1;
        end
        else if (!cpu_halted)
        begin
            op  = cpu_mem[cpu_pc][15:8];
            arg = cpu_mem[cpu_pc][7:0];
            ea  = arg[acpu_pkg::ADDR_BITS-1:0];
            a   = $signed(cpu_a);
            b   = $signed(cpu_b);
            case (op)
                acpu_pkg::OP_LDA: cpu_a = logic_result(cpu_mem[ea][7:0]);
                acpu_pkg::OP_STA: store_word(ea, cpu_a);
                acpu_pkg::OP_ADD: cpu_a = arith_result(a + b);
                acpu_pkg::OP_SUB: cpu_a = arith_result(a - b);
                acpu_pkg::OP_AND: cpu_a = logic_result(cpu_a & cpu_b);
                acpu_pkg::OP_OR:  cpu_a = logic_result(cpu_a | cpu_b);
                acpu_pkg::OP_XOR: cpu_a = logic_result(cpu_a ^ cpu_b);
                acpu_pkg::OP_NOT: cpu_a = logic_result(~cpu_a);
                acpu_pkg::OP_LLA: cpu_a = logic_result(arg);
                acpu_pkg::OP_JMP: cpu_pc = ea;
                acpu_pkg::OP_JZ:  if (cpu_zero) cpu_pc = ea;
                acpu_pkg::OP_IN:  cpu_a = logic_result(in_char);
                acpu_pkg::OP_OUT: rpt.strobe = 1'b1;
                acpu_pkg::OP_STP: cpu_halted = 1'b1;
                acpu_pkg::OP_LDB: cpu_b = logic_result(cpu_mem[ea][7:0]);
                acpu_pkg::OP_STB: store_word(ea, cpu_b);
                acpu_pkg::OP_LDC: cpu_c = logic_result(cpu_mem[ea][7:0]);
                acpu_pkg::OP_STC: store_word(ea, cpu_c);
                acpu_pkg::OP_MUL: cpu_a = arith_result(a * b);
                acpu_pkg::OP_DIV:
                begin
                    if (b == 0)
                    begin
                        // Division by zero: quotient 0, B kept, both flags set.
                        cpu_a    = 8'h00;
                        cpu_zero = 1'b1;
                        cpu_ovf  = 1'b1;
                    end
                    else
                    begin
                        rem   = a % b;
                        cpu_b = 8'(rem);
                        cpu_a = arith_result(a / b);
                    end
                end
                acpu_pkg::OP_LLB: cpu_b = logic_result(arg);
                acpu_pkg::OP_LLC: cpu_c = logic_result(arg);
                default: ;
            endcase
            // The increment follows every executed step, jumps included.
            cpu_pc = cpu_pc + acpu_pkg::ADDR_ONE;
        end
        rpt.out_char = rpt.strobe ? cpu_a : 8'h00;
        rpt.halted   = cpu_halted;
        rpt.acc      = cpu_a;
        rpt.pc       = 8'(cpu_pc);
        rpt.zero     = cpu_zero;
        rpt.ovf      = cpu_ovf;
        return rpt;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Queues the expectation and offers the item until the core takes it.
    // The expectation goes in before acceptance; results only follow
    // acceptance, so the order in the queue matches the output order.
    task automatic post_item(logic kind, logic [7:0] addr, logic [15:0] word,
                             logic [7:0] in_char, cpu_report_t rpt);
        pending_reports.push_back(rpt);
        items_offered++;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {in_char, word, addr};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic issue(logic kind, logic [7:0] addr, logic [15:0] word, logic [7:0] in_char);
        post_item(kind, addr, word, in_char, predict_report(kind, addr, word, in_char));
    endtask

    task automatic add_row(logic kind, logic [15:0] word, logic [7:0] addr, logic [7:0] in_char,
                           logic typed, logic [7:0] acc, logic zero, logic ovf);
        stim_rows.push_back('{kind, word, addr, in_char, typed, acc, zero, ovf});
    endtask

    task automatic run_row(stim_row_t row);
        cpu_report_t rpt;
        // A halted core fetches nothing, so no instruction is placed for it.
        if (row.kind == acpu_pkg::KIND_STEP && !cpu_halted)
            issue(acpu_pkg::KIND_LOAD, 8'(cpu_pc), row.word, 8'($urandom));
        rpt = predict_report(row.kind, row.addr, row.word, row.in_char);
        if (row.typed)
        begin
            rpt.acc  = row.acc;
            rpt.zero = row.zero;
            rpt.ovf  = row.ovf;
        end
        post_item(row.kind, row.addr, row.word, row.in_char, rpt);
    endtask

    // Mostly defined opcodes, stop excluded so the core keeps running; a
    // tenth of the time an undefined one.
    function automatic logic [7:0] random_opcode();
        logic [7:0] op;
        if ($urandom_range(0, 99) < 10)
            return 8'($urandom_range(25, 255));
        do
            op = 8'($urandom_range(0, 24));
        while (op == acpu_pkg::OP_STP);
        return op;
    endfunction

    // One well-formed random step: the word at pc is made defined (and
    // usually replaced by a fresh random instruction), any data word it
    // reads is made defined, then the step is issued. Reusing the word that
    // is already there replays older code, including jump landing sites.
    task automatic random_step();
        logic [15:0] w;
        w = cpu_mem[cpu_pc];
        if (!cpu_mem_valid[cpu_pc] || w[15:8] == acpu_pkg::OP_STP
            || $urandom_range(0, 99) < 75)
            issue(acpu_pkg::KIND_LOAD, 8'(cpu_pc), {random_opcode(), 8'($urandom)},
                  8'($urandom));
        w = cpu_mem[cpu_pc];
        if ((w[15:8] == acpu_pkg::OP_LDA || w[15:8] == acpu_pkg::OP_LDB
             || w[15:8] == acpu_pkg::OP_LDC)
            && !cpu_mem_valid[w[acpu_pkg::ADDR_BITS-1:0]])
            issue(acpu_pkg::KIND_LOAD, w[7:0], 16'($urandom), 8'($urandom));
        issue(acpu_pkg::KIND_STEP, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Samples the handshake at each rising edge, before the edge's updates
    // land, and drives tready for the next cycle. The long hold-off is
    // counted here so the sender keeps offering items meanwhile.
    initial
    begin : result_sink
        int          hold_left;
        bit          hold_taken;
        cpu_report_t want;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result item arrived with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("out_strobe", want.strobe, m_tuser);
                    check_field("out_char", want.out_char, m_tdata[7:0]);
                    check_field("halted", want.halted, m_tdata[8]);
                    check_field("acc_value", $signed(want.acc), $signed(m_tdata[16:9]));
                    check_field("prog_counter", want.pc, m_tdata[24:17]);
                    check_field("zero_flag", want.zero, m_tdata[25]);
                    check_field("overflow_flag", want.ovf, m_tdata[26]);
                end
            end
            if (hold_requested && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int start;
        int n;
        rst_n = 1'b0;
        cpu_a      = 8'h00;
        cpu_b      = 8'h00;
        cpu_c      = 8'h00;
        cpu_pc     = '0;
        cpu_zero   = 1'b0;
        cpu_ovf    = 1'b0;
        cpu_halted = 1'b0;
        foreach (cpu_mem[i])
        begin
            cpu_mem[i]       = 16'h0000;
            cpu_mem_valid[i] = 1'b0;
        end

        // Directed table. Step rows run from pc 0 upward; data lives at 0xF0-0xF4.
        //      kind                word                       addr   in_char typed acc z o
        // Right after reset every register and flag reads back as zero.
        add_row(acpu_pkg::KIND_LOAD, 16'h1280,                  8'hF0, 8'h00, 1, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_LOAD, 16'hAB7F,                  8'hF1, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDA, 8'hF0}, 8'h00, 8'h00, 1, 8'h80, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDB, 8'hF1}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDC, 8'hF0}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_ADD, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // -1 - 127 lands exactly on -128: no overflow.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_SUB, 8'h00}, 8'h00, 8'h00, 1, 8'h80, 0, 0);
        // -128 - 127 = -255: low byte 1, overflow.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_SUB, 8'h00}, 8'h00, 8'h00, 1, 8'h01, 0, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_MUL, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'h7F}, 8'h00, 8'h00, 1, 8'h7F, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLB, 8'h80}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // Subtracting -128 uses the true difference 255, with overflow.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_SUB, 8'h00}, 8'h00, 8'h00, 1, 8'hFF, 0, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_MUL, 8'h00}, 8'h00, 8'h00, 1, 8'h80, 0, 1);
        // -128 * -128 = 0x4000: zero low byte with overflow.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_MUL, 8'h00}, 8'h00, 8'h00, 1, 8'h00, 1, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'h80}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_ADD, 8'h00}, 8'h00, 8'h00, 1, 8'h00, 1, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_OR,  8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_AND, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_XOR, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_NOT, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // llc must land in C; stc and ldb then carry it over to B.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLC, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_STC, 8'hF2}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDB, 8'hF2}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // Division by zero: quotient 0, zero and overflow set.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_DIV, 8'h00}, 8'h00, 8'h00, 1, 8'h00, 1, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'h80}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLB, 8'hFF}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // -128 / -1 wraps back to -128 with overflow.
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_DIV, 8'h00}, 8'h00, 8'h00, 1, 8'h80, 0, 1);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'hF9}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLB, 8'h02}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_DIV, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_STA, 8'hF3}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_STB, 8'hF4}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDC, 8'hF3}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LDA, 8'hF4}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_IN,  8'h00}, 8'h00, 8'hA5, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_OUT, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_NOP0, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_NOP1, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_NOP2, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // An undefined opcode changes nothing but pc.
        add_row(acpu_pkg::KIND_STEP, {BAD_OPCODE, 8'h00},       8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_JMP, 8'h40}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_JZ,  8'h80}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // The stop rows run last, after the random part: a halted core stays
        // halted for good, and a write while halted still reaches memory.
        halt_first = stim_rows.size();
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_STP, 8'h00}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_LLA, 8'h55}, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_LOAD, {acpu_pkg::OP_LLA, 8'h55}, 8'h20, 8'h00, 0, 8'h00, 0, 0);
        add_row(acpu_pkg::KIND_STEP, {acpu_pkg::OP_IN,  8'h00}, 8'h00, 8'h3C, 0, 8'h00, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < halt_first; n++)
            run_row(stim_rows[n]);

        // Random part. Right at its start the receiver stops for a long
        // stretch while items keep coming, so the core backs up.
        hold_requested = 1'b1;
        start = items_offered;
        while (items_offered - start < RANDOM_ITEMS)
        begin
            if (items_offered - start < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 55;
            end
            else if (items_offered - start < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Now and then a stray write anywhere in memory.
            if ($urandom_range(0, 99) < 12)
                issue(acpu_pkg::KIND_LOAD, 8'($urandom), 16'($urandom), 8'($urandom));
            else
                random_step();
        end

        for (n = halt_first; n < stim_rows.size(); n++)
            run_row(stim_rows[n]);
        s_tvalid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
